// ----- design/bthin_pkg.sv -----
// ----------------------------------------------------------------------------
// bthin_pkg
// shared constants and types for the 3x3 binary thinning sub-pass
// ----------------------------------------------------------------------------
package bthin_pkg;

    // frame size limits
    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;

    // configuration register width and register index width
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    // position counters and the wider count used for compares
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int CNT_W = CFG_W + 1;

    localparam logic [CFG_W-1:0] DIM_MIN      = CFG_W'(3);
    localparam logic [CFG_W-1:0] WIDTH_MAX    = CFG_W'(MAX_COLS);
    localparam logic [CFG_W-1:0] HEIGHT_MAX   = CFG_W'(MAX_ROWS);
    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = CFG_IDX_W'(0),
        CFG_IMAGE_HEIGHT = CFG_IDX_W'(1)
    } cfg_reg_t;

    // control carried with a beat from the input register to the result register
    typedef struct packed {
        logic             bottom;   // bit shifted into the window bottom row
        logic             wr;       // pixel beat: update both line buffers
        logic [COL_W-1:0] col;      // line buffer column
        logic             emit;     // beat produces a result
        logic             inner;    // result pixel is not on the border
        logic             last;     // result is the final pixel of the frame
    } s1_ctl_t;

    // limit a written frame dimension to min..hi
    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] r;
        r = v;
        if (v < DIM_MIN) begin
            r = DIM_MIN;
        end
        if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

endpackage

// ----- design/bthin_ram.sv -----
// ----------------------------------------------------------------------------
// bthin_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module bthin_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/binary_thinning_subpass_3x3.sv -----
// ----------------------------------------------------------------------------
// binary_thinning_subpass_3x3
// one 3x3 thinning sub-pass over a binary image streamed in raster order
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake              payload
//  -------  ---  ---------------------  ------------------------------
//  in       in   in_valid / in_stall    pixel_in, is_filler
//  out      out  out_valid / out_stall  pixel_out, last_of_frame
//  cfg      in   cfg_write_en           cfg_index, cfg_data
//
//  one beat per clock in steady state while out_stall is low; a result is
//  formed from the input register into the output register when the beat
//  that completes its window drains, one row plus one pixel behind the input
//  the line buffers are rams with one read and one write per cycle; they are
//  not cleared, every interior decision reads only rows written in the
//  current frame and border results take only the center bit
//  reset clears position counters, window and handshake state at once
//  in_stall rises only when the input register holds a beat whose result
//  cannot move into a full, stalled output register
//
module binary_thinning_subpass_3x3 (
    input  logic                            clk,
    input  logic                            rst_n,
    // pixel input
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            pixel_in,
    input  logic                            is_filler,
    // result output
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            pixel_out,
    output logic                            last_of_frame,
    // configuration writes
    input  logic                            cfg_write_en,
    input  logic [bthin_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bthin_pkg::CFG_W-1:0]     cfg_data
);

    import bthin_pkg::*;

    // configuration
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    // input position, pending result count and output position
    logic [COL_W-1:0] col_reg,  col_next;
    logic [ROW_W-1:0] row_reg,  row_next;
    logic [CNT_W-1:0] pend_reg, pend_next;
    logic [COL_W-1:0] ocol_reg, ocol_next;
    logic [ROW_W-1:0] orow_reg, orow_next;

    // input register stage
    logic     s1_valid_reg;
    s1_ctl_t  s1_reg;
    s1_ctl_t  s1_next;
    logic     s1_load;
    logic     s1_go;

    // 3x3 window, bit 0 east, bit 1 center, bit 2 west
    logic [2:0] top_win_reg, top_win_next;
    logic [2:0] mid_win_reg, mid_win_next;
    logic [2:0] bot_win_reg, bot_win_next;

    // result register
    logic out_valid_reg;
    logic pixel_out_reg;
    logic last_reg;

    // line buffer access
    logic             upper_rd;
    logic             middle_rd;
    logic [COL_W-1:0] rd_addr;
    logic             ram_we;

    // decode of the current beat
    logic             in_acc;
    logic             at_start;
    logic             take;
    logic             emit;
    logic             drop;
    logic [CNT_W-1:0] width_ext;
    logic [CNT_W-1:0] height_ext;
    logic [CNT_W-1:0] w_plus1;
    logic [CNT_W-1:0] flush_k;
    logic [CNT_W-1:0] pend_eff;
    logic [COL_W-1:0] ocol_base;
    logic [ROW_W-1:0] orow_base;

    // result logic
    logic res_n, res_ne, res_e, res_w, res_s, res_se, res_p;
    logic clear_hit;
    logic result_bit;

    assign width_ext  = CNT_W'(width_reg);
    assign height_ext = CNT_W'(height_reg);
    assign w_plus1    = width_ext + CNT_W'(1);
    assign at_start   = (col_reg == '0) && (row_reg == '0);

    // the input register drains into the result register, or just shifts the
    // window when the beat produces no result
    assign s1_go    = s1_valid_reg && (!s1_reg.emit || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_go;
    assign in_acc   = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // beat decode and position bookkeeping
    // ------------------------------------------------------------------
    always_comb
    begin
        take      = 1'b0;
        emit      = 1'b0;
        drop      = 1'b0;
        pend_eff  = pend_reg;
        ocol_base = ocol_reg;
        orow_base = orow_reg;
        flush_k   = w_plus1 - pend_reg;
        rd_addr   = col_reg;
        if (is_filler)
        begin
            // a filler only counts right after a frame, while results wait
            take = at_start && (pend_reg != '0);
            emit = take;
            // flush reads wrap back to column zero on the last one
            rd_addr = (pend_reg == CNT_W'(1)) ? '0 : COL_W'(flush_k);
        end
        else
        begin
            // pixel arriving mid-flush: the rest of the old frame is dropped
            drop = at_start && (pend_reg != '0) && (pend_reg <= width_ext);
            if (drop)
            begin
                pend_eff  = '0;
                ocol_base = '0;
                orow_base = '0;
            end
            take = 1'b1;
            emit = (pend_eff == w_plus1);
        end
    end

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        pend_next = pend_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        s1_load   = in_acc && take;

        s1_next.bottom = pixel_in && !is_filler;
        s1_next.wr     = !is_filler;
        s1_next.col    = rd_addr;
        s1_next.emit   = emit;
        s1_next.inner  = (orow_base != '0)
                      && ((CNT_W'(orow_base) + CNT_W'(2)) <= height_ext)
                      && (ocol_base != '0)
                      && ((CNT_W'(ocol_base) + CNT_W'(2)) <= width_ext);
        s1_next.last   = ((CNT_W'(orow_base) + CNT_W'(1)) == height_ext)
                      && ((CNT_W'(ocol_base) + CNT_W'(1)) == width_ext);

        if (s1_load)
        begin
            if (is_filler)
            begin
                pend_next = pend_reg - CNT_W'(1);
            end
            else
            begin
                pend_next = emit ? pend_eff : pend_eff + CNT_W'(1);
                if ((CNT_W'(col_reg) + CNT_W'(1)) == width_ext)
                begin
                    col_next = '0;
                    if ((CNT_W'(row_reg) + CNT_W'(1)) == height_ext)
                    begin
                        row_next = '0;
                    end
                    else
                    begin
                        row_next = row_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end

            ocol_next = ocol_base;
            orow_next = orow_base;
            if (emit)
            begin
                if (s1_next.last)
                begin
                    ocol_next = '0;
                    orow_next = '0;
                end
                else if ((CNT_W'(ocol_base) + CNT_W'(1)) == width_ext)
                begin
                    ocol_next = '0;
                    orow_next = orow_base + ROW_W'(1);
                end
                else
                begin
                    ocol_next = ocol_base + COL_W'(1);
                end
            end
        end
    end

    // configuration writes restart the frame position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            pend_reg   <= '0;
            ocol_reg   <= '0;
            orow_reg   <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:
                begin
                    width_reg <= clamp_dim(cfg_data, WIDTH_MAX);
                end
                CFG_IMAGE_HEIGHT:
                begin
                    height_reg <= clamp_dim(cfg_data, HEIGHT_MAX);
                end
                default:
                begin
                end
            endcase
            col_reg  <= '0;
            row_reg  <= '0;
            pend_reg <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            pend_reg <= pend_next;
            ocol_reg <= ocol_next;
            orow_reg <= orow_next;
        end
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_reg <= s1_next;
        end
    end

    // ------------------------------------------------------------------
    // line buffers: upper takes the old middle row, middle takes the pixel
    // ------------------------------------------------------------------
    assign ram_we = s1_go && s1_reg.wr;

    bthin_ram #(
        .WIDTH (1),
        .DEPTH (MAX_COLS)
    ) u_upper_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_reg.col),
        .wdata (middle_rd),
        .re    (s1_load),
        .raddr (rd_addr),
        .rdata (upper_rd)
    );

    bthin_ram #(
        .WIDTH (1),
        .DEPTH (MAX_COLS)
    ) u_middle_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_reg.col),
        .wdata (s1_reg.bottom),
        .re    (s1_load),
        .raddr (rd_addr),
        .rdata (middle_rd)
    );

    // ------------------------------------------------------------------
    // window shift and thinning decision
    // ------------------------------------------------------------------
    assign top_win_next = {top_win_reg[1:0], upper_rd};
    assign mid_win_next = {mid_win_reg[1:0], middle_rd};
    assign bot_win_next = {bot_win_reg[1:0], s1_reg.bottom};

    assign res_n  = top_win_next[1];
    assign res_ne = top_win_next[0];
    assign res_w  = mid_win_next[2];
    assign res_p  = mid_win_next[1];
    assign res_e  = mid_win_next[0];
    assign res_s  = bot_win_next[1];
    assign res_se = bot_win_next[0];

    // east clear, west set, and one of the two north/south patterns
    assign clear_hit = !res_e && res_w
                    && ((res_n && !res_se && !res_s) || (!res_n && !res_ne && res_s));
    assign result_bit = res_p && !(s1_reg.inner && clear_hit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_win_reg <= '0;
            mid_win_reg <= '0;
            bot_win_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            top_win_reg <= '0;
            mid_win_reg <= '0;
            bot_win_reg <= '0;
        end
        else if (s1_go)
        begin
            top_win_reg <= top_win_next;
            mid_win_reg <= mid_win_next;
            bot_win_reg <= bot_win_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_reg.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_reg.emit)
        begin
            pixel_out_reg <= result_bit;
            last_reg      <= s1_reg.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_out     = pixel_out_reg;
    assign last_of_frame = last_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= w_plus1)
        else $error("pending count above one row plus one pixel");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W'(col_reg) < width_ext) && (CNT_W'(ocol_reg) < width_ext))
        else $error("column counter outside the image width");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W'(row_reg) < height_ext) && (CNT_W'(orow_reg) < height_ext))
        else $error("row counter outside the image height");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && s1_load) |-> (rd_addr != s1_reg.col))
        else $error("line buffer read and write hit the same column");

    a_drain_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_load && emit && s1_next.last && !cfg_write_en)
            |=> ((ocol_reg == '0) && (orow_reg == '0)))
        else $error("output position did not wrap after the last pixel");

endmodule
